// ----- rtl/ett_pkg.sv -----
// Shared constants for the Euler totient block.
// No dependencies; imported by ett_div and euler_totient_trial_division.
package ett_pkg;

   // Default operand width of the block.
   localparam int VALUE_WIDTH_DEF = 32;

   // First trial divisor.
   localparam int TRIAL_START = 2;

endpackage

// ----- rtl/euler_totient_trial_division.sv -----
// Euler totient unit: finds phi(n) by trial division on a shared bit-serial divider.
// Depends on ett_pkg and ett_div.
//
// One word is taken when start is high and busy is low; busy stays high until the
// result has been computed. Every step of the factor search is one pass of the
// radix-2 divider. A word needs roughly (trial divisors tried + prime factors found
// with multiplicity + distinct primes + 1) such passes, so the worst case is a
// large prime: about sqrt(n) passes. A zero input is answered with 0 in the cycle
// right after it is taken. The result appears on rsp_totient for exactly one cycle
// with rsp_valid high; the receiver cannot stall it, and a new word may be started
// in that same cycle.
module euler_totient_trial_division
   import ett_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [VALUE_WIDTH-1:0] req_value_in,
   output logic                   rsp_valid,
   output logic [VALUE_WIDTH-1:0] rsp_totient
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_TEST  = 3'd1;
   localparam logic [2:0] S_ACC   = 3'd2;
   localparam logic [2:0] S_STRIP = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [VALUE_WIDTH-1:0] rest_ff, rest_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [VALUE_WIDTH-1:0] trial_ff, trial_in;
   logic                   go_ff, go_in;
   logic [VALUE_WIDTH-1:0] op_a_ff, op_a_in;
   logic [VALUE_WIDTH-1:0] op_b_ff, op_b_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_totient_ff, rsp_totient_in;

   logic                   div_done;
   logic [VALUE_WIDTH-1:0] div_q;
   logic [VALUE_WIDTH-1:0] div_r;
   logic [VALUE_WIDTH-1:0] trial_next;

   ett_div #(
      .WIDTH(VALUE_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (go_ff),
      .dividend (op_a_ff),
      .divisor  (op_b_ff),
      .done     (div_done),
      .quotient (div_q),
      .remainder(div_r)
   );

   assign trial_next = trial_ff + VALUE_WIDTH'(1);

   // Each division by a prime p is exact, so acc / p * (p - 1) equals acc - acc / p.
   always_comb begin
      state_in       = state_ff;
      rest_in        = rest_ff;
      acc_in         = acc_ff;
      trial_in       = trial_ff;
      go_in          = 1'b0;
      op_a_in        = op_a_ff;
      op_b_in        = op_b_ff;
      rsp_valid_in   = 1'b0;
      rsp_totient_in = rsp_totient_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_value_in == '0) begin
                  rsp_valid_in   = 1'b1;
                  rsp_totient_in = '0;
               end else begin
                  rest_in  = req_value_in;
                  acc_in   = req_value_in;
                  trial_in = VALUE_WIDTH'(TRIAL_START);
                  op_a_in  = req_value_in;
                  op_b_in  = VALUE_WIDTH'(TRIAL_START);
                  go_in    = 1'b1;
                  state_in = S_TEST;
               end
            end
         end
         S_TEST: begin
            if (div_done) begin
               if (trial_ff > div_q) begin
                  // The trial divisor has passed the square root of the cofactor.
                  if (rest_ff != VALUE_WIDTH'(1)) begin
                     op_a_in  = acc_ff;
                     op_b_in  = rest_ff;
                     go_in    = 1'b1;
                     state_in = S_FIN;
                  end else begin
                     rsp_valid_in   = 1'b1;
                     rsp_totient_in = acc_ff;
                     state_in       = S_IDLE;
                  end
               end else if (div_r == '0) begin
                  rest_in  = div_q;
                  op_a_in  = acc_ff;
                  op_b_in  = trial_ff;
                  go_in    = 1'b1;
                  state_in = S_ACC;
               end else begin
                  trial_in = trial_next;
                  op_a_in  = rest_ff;
                  op_b_in  = trial_next;
                  go_in    = 1'b1;
               end
            end
         end
         S_ACC: begin
            if (div_done) begin
               acc_in   = acc_ff - div_q;
               op_a_in  = rest_ff;
               op_b_in  = trial_ff;
               go_in    = 1'b1;
               state_in = S_STRIP;
            end
         end
         S_STRIP: begin
            if (div_done) begin
               if (div_r == '0) begin
                  rest_in = div_q;
                  op_a_in = div_q;
                  op_b_in = trial_ff;
                  go_in   = 1'b1;
               end else begin
                  trial_in = trial_next;
                  op_a_in  = rest_ff;
                  op_b_in  = trial_next;
                  go_in    = 1'b1;
                  state_in = S_TEST;
               end
            end
         end
         S_FIN: begin
            if (div_done) begin
               rsp_valid_in   = 1'b1;
               rsp_totient_in = acc_ff - div_q;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rest_ff        <= rest_in;
      acc_ff         <= acc_in;
      trial_ff       <= trial_in;
      op_a_ff        <= op_a_in;
      op_b_ff        <= op_b_in;
      rsp_totient_ff <= rsp_totient_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_totient = rsp_totient_ff;

endmodule

// ----- rtl/ett_div.sv -----
// Radix-2 restoring divider: one quotient bit per cycle.
// Depends on ett_pkg for the default width.
module ett_div
   import ett_pkg::*;
#(
   parameter int WIDTH = VALUE_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int CntW = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;

   logic [WIDTH:0]   rem_shift;
   logic [WIDTH:0]   diff;

   // The dividend shifts out of the top of quo_ff while quotient bits enter at the bottom.
   assign rem_shift = {rem_ff, quo_ff[WIDTH-1]};
   assign diff      = rem_shift - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(WIDTH);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[WIDTH]) begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
